@@ hw/rtl/rhc_pkg.sv @@
// rhc_pkg: widths, pipeline sizing and stage types of the RGB to HSV converter.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package rhc_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int HUE_BITS     = 16;
    localparam int SAT_BITS     = 17;

    // Quotient bits: one integer bit plus 16 fraction bits.
    localparam int QW   = 17;
    // Divisor holds 6*D, remainder holds twice that.
    localparam int DIVW = CHANNEL_BITS + 3;
    localparam int REMW = DIVW + 1;

    localparam int STEPS_PER_STAGE = 4;
    localparam int DIV_STAGES      = (QW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int NUM_STAGES      = DIV_STAGES + 2;

    typedef logic [CHANNEL_BITS-1:0] t_chan;

    // max/min stage
    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
        t_chan hi;
        t_chan lo;
    } t_mm_st;

    // divider stage: hue and saturation dividers side by side
    typedef struct packed {
        logic [REMW-1:0] hue_rem;
        logic [DIVW-1:0] hue_div;
        logic [QW-1:0]   hue_q;
        logic [REMW-1:0] sat_rem;
        logic [DIVW-1:0] sat_div;
        logic [QW-1:0]   sat_q;
        t_chan           hi;
    } t_div_st;

endpackage

`default_nettype wire

@@ hw/rtl/rhc_ifs.sv @@
// rhc_ifs: valid/ready channel interfaces for pixels in (RGB) and out (HSV).
// Depends on rhc_pkg for channel and result widths.
`default_nettype none

interface rhc_pix_if
    import rhc_pkg::*;
();
    logic  valid;
    logic  ready;
    t_chan red;
    t_chan green;
    t_chan blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rhc_hsv_if
    import rhc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [HUE_BITS-1:0] hue;
    logic [SAT_BITS-1:0] saturation;
    t_chan               value_level;

    modport source (output valid, hue, saturation, value_level, input ready);
    modport sink   (input valid, hue, saturation, value_level, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rgb_to_hsv_converter_top.sv @@
// rgb_to_hsv_converter_top: pipelined RGB to HSV pixel converter.
// Depends on rhc_pkg and the channel interfaces in rhc_ifs.
//
// Usage:
//   i_pix  - sink channel, one RGB pixel per beat (valid/ready).
//   o_hsv  - source channel, one HSV result per beat, in input order.
//   Hue is a Q0.16 fraction of a turn, saturation has 65536 as 1.0,
//   value_level is the largest channel.
// Pipeline: max/min stage, hue numerator / divisor stage, then
//   DIV_STAGES restoring-division stages (up to four quotient bits each) that
//   run the hue and saturation divisions side by side.
// Throughput: one pixel per clock while o_hsv.ready holds; every stage is a full register step.
// Stall: each stage advances when it is empty or the stage after it
//   advances, so bubbles collapse and a stalled receiver backs the pipe up
//   stage by stage; i_pix.ready drops only when every stage holds a beat.
// Reset: synchronous, active low; clears all valid bits, payload is not reset.
// Gray and black pixels are forced to zero hue and saturation by feeding
//   the dividers a zero dividend over a divisor of one.
`default_nettype none

module rgb_to_hsv_converter_top
    import rhc_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    rhc_pix_if.sink   i_pix,
    rhc_hsv_if.source o_hsv
);

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] en;

    t_mm_st  r_mm,  n_mm;
    t_div_st r_prep, n_prep;
    t_div_st r_div [DIV_STAGES];
    t_div_st n_div [DIV_STAGES];
    t_div_st s_div_in [DIV_STAGES];

    // ---------------------------------------------------------------
    // Stage advance chain: a stage loads when empty or when it empties.
    // ---------------------------------------------------------------
    always_comb begin
        en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || o_hsv.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_pix.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: largest and smallest channel
    // ---------------------------------------------------------------
    always_comb begin
        t_chan hi_rg;
        t_chan lo_rg;
        hi_rg      = (i_pix.red > i_pix.green) ? i_pix.red : i_pix.green;
        lo_rg      = (i_pix.red < i_pix.green) ? i_pix.red : i_pix.green;
        n_mm.red   = i_pix.red;
        n_mm.green = i_pix.green;
        n_mm.blue  = i_pix.blue;
        n_mm.hi    = (i_pix.blue > hi_rg) ? i_pix.blue : hi_rg;
        n_mm.lo    = (i_pix.blue < lo_rg) ? i_pix.blue : lo_rg;
    end

    // ---------------------------------------------------------------
    // Stage 1: D, sector numerator, divisor 6*D
    // ---------------------------------------------------------------
    always_comb begin
        logic [DIVW-1:0] d;
        logic [DIVW-1:0] base;
        logic [DIVW-1:0] ofs;
        logic            add;
        logic [DIVW-1:0] num;
        logic            gray;

        d    = DIVW'(r_mm.hi - r_mm.lo);
        gray = (r_mm.hi == r_mm.lo);   // also covers black

        // Sector rules; base is 1, 3 or 5 times D, offset is max minus a channel.
        priority if (r_mm.red == r_mm.hi) begin
            if (r_mm.green == r_mm.lo) begin
                base = (d << 2) + d;
                ofs  = DIVW'(r_mm.hi - r_mm.blue);
                add  = 1'b1;
            end else begin
                base = d;
                ofs  = DIVW'(r_mm.hi - r_mm.green);
                add  = 1'b0;
            end
        end else if (r_mm.green == r_mm.hi) begin
            if (r_mm.blue == r_mm.lo) begin
                base = d;
                ofs  = DIVW'(r_mm.hi - r_mm.red);
                add  = 1'b1;
            end else begin
                base = (d << 1) + d;
                ofs  = DIVW'(r_mm.hi - r_mm.blue);
                add  = 1'b0;
            end
        end else begin
            if (r_mm.red == r_mm.lo) begin
                base = (d << 1) + d;
                ofs  = DIVW'(r_mm.hi - r_mm.green);
                add  = 1'b1;
            end else begin
                base = (d << 2) + d;
                ofs  = DIVW'(r_mm.hi - r_mm.red);
                add  = 1'b0;
            end
        end

        num = add ? (base + ofs) : (base - ofs);

        n_prep.hi    = r_mm.hi;
        n_prep.hue_q = '0;
        n_prep.sat_q = '0;
        if (gray) begin
            // zero over one: both quotients come out zero
            n_prep.hue_rem = '0;
            n_prep.hue_div = DIVW'(1);
            n_prep.sat_rem = '0;
            n_prep.sat_div = DIVW'(1);
        end else begin
            n_prep.hue_rem = REMW'(num);
            n_prep.hue_div = (d << 2) + (d << 1);
            n_prep.sat_rem = REMW'(d);
            n_prep.sat_div = DIVW'(r_mm.hi);
        end
    end

    // ---------------------------------------------------------------
    // Division stages: restoring division, quotient MSB first.
    // Dividend <= divisor on entry, so 17 steps give floor(65536*n/d).
    // ---------------------------------------------------------------
    assign s_div_in[0] = r_prep;
    for (genvar k = 1; k < DIV_STAGES; k++) begin : g_div_link
        assign s_div_in[k] = r_div[k-1];
    end

    always_comb begin
        t_div_st w;
        for (int k = 0; k < DIV_STAGES; k++) begin
            w = s_div_in[k];
            for (int j = 0; j < STEPS_PER_STAGE; j++) begin
                if (k * STEPS_PER_STAGE + j < QW) begin
                    if (w.hue_rem >= REMW'(w.hue_div)) begin
                        w.hue_rem = w.hue_rem - REMW'(w.hue_div);
                        w.hue_q   = {w.hue_q[QW-2:0], 1'b1};
                    end else begin
                        w.hue_q   = {w.hue_q[QW-2:0], 1'b0};
                    end
                    w.hue_rem = {w.hue_rem[REMW-2:0], 1'b0};

                    if (w.sat_rem >= REMW'(w.sat_div)) begin
                        w.sat_rem = w.sat_rem - REMW'(w.sat_div);
                        w.sat_q   = {w.sat_q[QW-2:0], 1'b1};
                    end else begin
                        w.sat_q   = {w.sat_q[QW-2:0], 1'b0};
                    end
                    w.sat_rem = {w.sat_rem[REMW-2:0], 1'b0};
                end
            end
            n_div[k] = w;
        end
    end

    // ---------------------------------------------------------------
    // Payload registers (no reset)
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_mm <= n_mm;
        end
        if (en[1]) begin
            r_prep <= n_prep;
        end
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (en[k+2]) begin
                r_div[k] <= n_div[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // Output: hue wraps modulo one turn (drop the integer bit)
    // ---------------------------------------------------------------
    assign o_hsv.valid       = r_vld[NUM_STAGES-1];
    assign o_hsv.hue         = r_div[DIV_STAGES-1].hue_q[HUE_BITS-1:0];
    assign o_hsv.saturation  = SAT_BITS'(r_div[DIV_STAGES-1].sat_q);
    assign o_hsv.value_level = r_div[DIV_STAGES-1].hi;

endmodule

`default_nettype wire
